FILE: rtl/tsma_pkg.sv
// shared types, constants and the crc-8 byte update for the ts mode adaptation block
// no dependencies
package tsma_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = $clog2(PACKET_BYTES + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CRC_POLY = 8'hD5;

    localparam logic ADAPT_NORMAL = 1'b0;
    localparam logic ADAPT_HEM    = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
    } out_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // msb-first crc-8 over one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/tsma_front.sv
// front end: accepts bytes, tracks packet position and crc, classifies each transaction
// depends on tsma_pkg
module tsma_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adapt_mode_we,
    input  logic                     adapt_mode_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  tsma_pkg::in_item_t       in_data,
    input  tsma_pkg::queue_status_t  q_status,
    output logic                     push,
    output tsma_pkg::out_item_t      push_data
);

    logic                       mode_reg;
    logic [7:0]                 prev_crc_reg;
    logic [7:0]                 prev_crc_next;
    logic [7:0]                 crc_reg;
    logic [7:0]                 crc_next;
    logic [tsma_pkg::POS_W-1:0] pos_reg;
    logic [tsma_pkg::POS_W-1:0] pos_next;
    logic [tsma_pkg::POS_W-1:0] pos_inc;
    logic                       accept;
    logic                       emit;
    tsma_pkg::out_item_t        item;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign pos_inc  = pos_reg + tsma_pkg::POS_W'(1);

    always_comb
    begin
        prev_crc_next   = prev_crc_reg;
        crc_next        = crc_reg;
        pos_next        = pos_reg;
        emit            = 1'b0;
        item.out_byte   = in_data.data_byte;
        item.packet_end = 1'b0;
        priority if (in_data.packet_start)
        begin
            crc_next      = 8'h00;
            pos_next      = tsma_pkg::POS_W'(1);
            emit          = (mode_reg == tsma_pkg::ADAPT_NORMAL);
            item.out_byte = prev_crc_reg;
        end
        else if (pos_reg == '0 || pos_reg >= tsma_pkg::POS_W'(tsma_pkg::PACKET_BYTES))
        begin
            emit = 1'b0;
        end
        else
        begin
            crc_next = tsma_pkg::crc8_update(crc_reg, in_data.data_byte);
            pos_next = pos_inc;
            emit     = 1'b1;
            if (pos_inc >= tsma_pkg::POS_W'(tsma_pkg::PACKET_BYTES))
            begin
                item.packet_end = 1'b1;
                pos_next        = '0;
                if (mode_reg == tsma_pkg::ADAPT_NORMAL)
                begin
                    prev_crc_next = crc_next;
                end
            end
        end
    end

    assign push      = accept && emit;
    assign push_data = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= tsma_pkg::ADAPT_NORMAL;
            prev_crc_reg <= 8'h00;
            crc_reg      <= 8'h00;
            pos_reg      <= '0;
        end
        else
        begin
            if (adapt_mode_we)
            begin
                mode_reg <= adapt_mode_wdata;
            end
            if (accept)
            begin
                prev_crc_reg <= prev_crc_next;
                crc_reg      <= crc_next;
                pos_reg      <= pos_next;
            end
        end
    end

    // a packet's last byte closes the packet
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.packet_end |=> pos_reg == '0)
        else $error("position not cleared after last byte");

endmodule

FILE: rtl/tsma_queue.sv
// short queue between the front end and the output stage
// depends on tsma_pkg
module tsma_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  tsma_pkg::out_item_t      push_data,
    input  logic                     pop,
    output tsma_pkg::out_item_t      pop_data,
    output tsma_pkg::queue_status_t  status
);

    tsma_pkg::out_item_t        entry_reg [tsma_pkg::QUEUE_DEPTH];
    logic [tsma_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [tsma_pkg::PTR_W-1:0] wr_ptr_next;
    logic [tsma_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [tsma_pkg::PTR_W-1:0] rd_ptr_next;
    logic [tsma_pkg::CNT_W-1:0] count_reg;
    logic [tsma_pkg::CNT_W-1:0] count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == tsma_pkg::CNT_W'(tsma_pkg::QUEUE_DEPTH));
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tsma_pkg::PTR_W'(tsma_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + tsma_pkg::PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tsma_pkg::PTR_W'(tsma_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + tsma_pkg::PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + tsma_pkg::CNT_W'(1);
            2'b01:   count_next = count_reg - tsma_pkg::CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

endmodule

FILE: rtl/tsma_back.sv
// output stage: drains the queue into the output register
// depends on tsma_pkg
module tsma_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tsma_pkg::queue_status_t  q_status,
    input  tsma_pkg::out_item_t      q_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output tsma_pkg::out_item_t      out_data
);

    logic                out_valid_reg;
    logic                out_valid_next;
    tsma_pkg::out_item_t out_data_reg;

    assign pop            = !q_status.empty && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= q_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/ts_mode_adaptation_crc8_unit.sv
// top level of the transport stream mode adaptation block with crc-8 sync replacement
// depends on tsma_pkg, tsma_front, tsma_queue and tsma_back
//
// input channel: in_valid / in_stall / in_data, one packet byte per transaction,
// packet_start marking the sync byte. output channel: out_valid / out_stall /
// out_data, one adapted byte per transaction, packet_end on the last packet byte.
// in normal mode the sync byte is replaced by the crc-8 of the previous packet's
// bytes 1 to 187; in high efficiency mode it is dropped. bytes outside a packet
// are dropped. adapt_mode is written through adapt_mode_we / adapt_mode_wdata.
// throughput: one byte per cycle while the queue is not full, bounded by the byte-wise
// crc update in the front end. an accepted byte is written into the queue and
// then moved into the output register when that register is free or not stalled.
// reset clears the mode (normal), the position, both crc registers, the queue
// and the output valid flag. while the receiver stalls, the output register holds
// and the four-entry queue fills; in_stall rises once the queue is full.
module ts_mode_adaptation_crc8_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adapt_mode_we,
    input  logic                adapt_mode_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  tsma_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tsma_pkg::out_item_t out_data
);

    tsma_pkg::queue_status_t q_status;
    tsma_pkg::out_item_t     push_data;
    tsma_pkg::out_item_t     pop_data;
    logic                    push;
    logic                    pop;

    tsma_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .adapt_mode_we    (adapt_mode_we),
        .adapt_mode_wdata (adapt_mode_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .q_status         (q_status),
        .push             (push),
        .push_data        (push_data)
    );

    tsma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    tsma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for ts_mode_adaptation_crc8_unit: queued packet bytes, own crc-8 predictor
// depends on tsma_pkg and the rtl of the unit
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;
    localparam int LONG_HOLD   = 80;
    localparam int HOLD_AT     = 60;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                adapt_mode_we    = 1'b0;
    logic                adapt_mode_wdata = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_stall;
    tsma_pkg::in_item_t  in_data          = '0;
    logic                out_valid;
    logic                out_stall        = 1'b0;
    tsma_pkg::out_item_t out_data;

    tsma_pkg::in_item_t  pending_bytes[$];
    tsma_pkg::out_item_t expected_bytes[$];
    int        bytes_issued     = 0;
    int        bytes_accepted   = 0;
    int        mismatch_count   = 0;
    int        cycle_count      = 0;
    int        idle_pct         = 17;
    int        stall_pct        = 17;
    int        hold_left        = 0;
    bit        long_hold_done   = 1'b0;
    logic      in_fire          = 1'b0;

    // predictor state
    logic       pred_mode     = tsma_pkg::ADAPT_NORMAL;
    logic [7:0] pred_prev_crc = 8'h00;
    logic [7:0] pred_run_crc  = 8'h00;
    int         pred_pos      = 0;

    ts_mode_adaptation_crc8_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .adapt_mode_we    (adapt_mode_we),
        .adapt_mode_wdata (adapt_mode_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? tsma_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // returns 1 when the byte yields an output byte
    function automatic bit adapt_byte(tsma_pkg::in_item_t it, output tsma_pkg::out_item_t res);
        res = '0;
        if (it.packet_start)
        begin
            pred_run_crc = 8'h00;
            pred_pos     = 1;
            res.out_byte = pred_prev_crc;
            return pred_mode == tsma_pkg::ADAPT_NORMAL;
        end
        if (pred_pos == 0)
        begin
            return 1'b0;
        end
        pred_run_crc = crc8_next(pred_run_crc, it.data_byte);
        pred_pos++;
        res.out_byte = it.data_byte;
        if (pred_pos >= tsma_pkg::PACKET_BYTES)
        begin
            res.packet_end = 1'b1;
            if (pred_mode == tsma_pkg::ADAPT_NORMAL)
            begin
                pred_prev_crc = pred_run_crc;
            end
            pred_pos = 0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int expv, int gotv);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s expected %0h got %0h",
                 cycle_count, what, expv, gotv);
    endtask

    task automatic push_byte(logic [7:0] d, logic s);
        tsma_pkg::in_item_t it;
        it.data_byte    = d;
        it.packet_start = s;
        pending_bytes.push_back(it);
        bytes_issued++;
    endtask

    function automatic logic [7:0] random_byte();
        if ($urandom_range(7) == 0)
        begin
            return 8'h47;
        end
        return 8'($urandom_range(255));
    endfunction

    // mostly whole packets, some cut short, some stray bytes and overruns
    task automatic queue_random_stream(int target);
        int n;
        int kind;
        int len;
        n = 0;
        while (n < target)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                len = $urandom_range(1, 5);
                repeat (len) push_byte(random_byte(), 1'b0);
            end
            else
            begin
                len = (kind < 22) ? $urandom_range(1, tsma_pkg::PACKET_BYTES - 1)
                                  : tsma_pkg::PACKET_BYTES;
                push_byte(random_byte(), 1'b1);
                repeat (len - 1) push_byte(random_byte(), 1'b0);
                if (kind >= 95)
                begin
                    repeat ($urandom_range(1, 3)) push_byte(random_byte(), 1'b0);
                    len += 3;
                end
            end
            n += len;
        end
        // leave a packet open across the next mode write now and then
        if ($urandom_range(1) == 1)
        begin
            push_byte(random_byte(), 1'b1);
            repeat ($urandom_range(1, 150)) push_byte(random_byte(), 1'b0);
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (bytes_accepted != bytes_issued || expected_bytes.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_mode(logic m);
        @(negedge clk);
        adapt_mode_we    <= 1'b1;
        adapt_mode_wdata <= m;
        @(negedge clk);
        adapt_mode_we    <= 1'b0;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_data  <= pending_bytes.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!long_hold_done && bytes_accepted >= HOLD_AT)
        begin
            out_stall      <= 1'b1;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        tsma_pkg::out_item_t want;
        tsma_pkg::out_item_t res;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (adapt_mode_we)
            begin
                pred_mode = adapt_mode_wdata;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected transaction, out_byte", 0, out_data.out_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        report_mismatch("out_byte", want.out_byte, out_data.out_byte);
                    end
                    if (out_data.packet_end !== want.packet_end)
                    begin
                        report_mismatch("packet_end", want.packet_end, out_data.packet_end);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                bytes_accepted++;
                if (adapt_byte(in_data, res))
                begin
                    expected_bytes.push_back(res);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        write_mode(tsma_pkg::ADAPT_NORMAL);
        @(posedge clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h47, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h5A, 1'b0);
        wait_drained();

        write_mode(tsma_pkg::ADAPT_HEM);
        @(posedge clk);
        push_byte(8'h47, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hA5, 1'b0);
        wait_drained();

        write_mode(tsma_pkg::ADAPT_NORMAL);
        @(posedge clk);
        queue_random_stream(150);
        wait_drained();

        write_mode(tsma_pkg::ADAPT_HEM);
        idle_pct  <= 0;
        stall_pct <= 0;
        @(posedge clk);
        queue_random_stream(100);
        wait_drained();

        write_mode(tsma_pkg::ADAPT_NORMAL);
        idle_pct  <= 17;
        stall_pct <= 17;
        @(posedge clk);
        queue_random_stream(150);
        wait_drained();

        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tsma_pkg.sv
rtl/tsma_front.sv
rtl/tsma_queue.sv
rtl/tsma_back.sv
rtl/ts_mode_adaptation_crc8_unit.sv
tb/testbench.sv
